### rtl/ofa_pkg.sv
// Shared constants for the orthonormal frame block.
`timescale 1ns / 1ps
package ofa_pkg;

	// Fixed-point formats
	localparam int ALIGN_W = 16;    // inputs after alignment, Q4.12
	localparam int OUT_W   = 16;    // frame components, Q1.14
	localparam int ZR_W    = 21;    // orthogonalized hint, Q.14
	localparam int CR_W    = 31;    // cross product, Q2.28
	localparam int THR_W   = 20;    // degenerate threshold register

	localparam int ONE_Q14 = 16384;
	localparam int ONE_Q12 = 4096;

	localparam logic [THR_W-1:0] THRESH_RESET = 20'd256;

endpackage

### rtl/ofa_norm.sv
// Pipelined vector normalizer: sum of squares, pipelined square root, pipelined divide.
`timescale 1ns / 1ps
module ofa_norm #(
	parameter int W      = 16,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic signed [W-1:0]             in_vec [3],
	input  logic [SIDE_W-1:0]               in_side,
	output logic                            out_valid,
	output logic signed [ofa_pkg::OUT_W-1:0] out_vec [3],
	output logic [SIDE_W-1:0]               out_side
);

	localparam int SQ_W   = 2 * W;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int REM_W  = 34;
	localparam int MK_W   = 31;
	localparam int DIV_W  = 31;
	localparam int NUM_W  = 47;
	localparam int QUO_W  = 16;
	localparam int K_W    = 5;
	localparam int SQRT_N = 32;
	localparam int DIV_N  = QUO_W;
	localparam int NSTG   = 4 + SQRT_N + 1 + DIV_N + 1;

	// valid chain, one bit per stage
	logic [NSTG-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[NSTG-1];

	// stage 1: magnitudes and squares
	logic [W-1:0]      mag_c [3];
	logic [W-1:0]      mag_s1 [3];
	logic [SQ_W-1:0]   sq_s1 [3];
	logic [2:0]        neg_s1;
	logic [SIDE_W-1:0] side_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
		end
	end

	// stage 2: sum of squares
	logic [RAD_W-1:0]  sum_s2;
	logic [W-1:0]      mag_s2 [3];
	logic [2:0]        neg_s2;
	logic [SIDE_W-1:0] side_s2;

	// stage 3: shift count so the radicand lands in [2^60, 2^62)
	logic [K_W-1:0]    k_c;
	logic [K_W-1:0]    k_s3;
	logic [RAD_W-1:0]  sum_s3;
	logic              zero_s3;
	logic [W-1:0]      mag_s3 [3];
	logic [2:0]        neg_s3;
	logic [SIDE_W-1:0] side_s3;

	always_comb begin
		k_c = '0;
		for (int t = 30; t >= 0; t--) begin
			if ((sum_s2 >> (60 - 2 * t)) != '0) begin
				k_c = K_W'(t);
			end
		end
	end

	// square root pipeline, one result bit per stage; index 0 is the shifted radicand
	logic [RAD_W-1:0]  srad [0:SQRT_N];
	logic [REM_W-1:0]  srem [0:SQRT_N];
	logic [ROOT_W-1:0] sroot [0:SQRT_N];
	logic [MK_W-1:0]   svk [0:SQRT_N][0:2];
	logic [2:0]        sneg [0:SQRT_N];
	logic              szero [0:SQRT_N];
	logic [SIDE_W-1:0] sside [0:SQRT_N];

	logic [REM_W+1:0]  s_cat [0:SQRT_N-1];
	logic [REM_W+1:0]  s_trial [0:SQRT_N-1];
	logic [SQRT_N-1:0] s_ge;

	always_comb begin
		for (int j = 0; j < SQRT_N; j++) begin
			s_cat[j]   = {srem[j], srad[j][RAD_W-1 -: 2]};
			s_trial[j] = (REM_W + 2)'({sroot[j], 2'b01});
			s_ge[j]    = s_cat[j] >= s_trial[j];
		end
	end

	// divide pipeline: rounded |v|*2^(14+k) / r, one quotient bit per stage
	logic [NUM_W-1:0]  drem [0:DIV_N][0:2];
	logic [QUO_W-1:0]  dquo [0:DIV_N][0:2];
	logic [DIV_W-1:0]  dd [0:DIV_N];
	logic [2:0]        dneg [0:DIV_N];
	logic              dzero [0:DIV_N];
	logic [SIDE_W-1:0] dside [0:DIV_N];

	logic [NUM_W-1:0]  d_sub [0:DIV_N-1];
	logic              d_ge [0:DIV_N-1][0:2];

	always_comb begin
		for (int t = 0; t < DIV_N; t++) begin
			d_sub[t] = NUM_W'(dd[t]) << (DIV_N - 1 - t);
			for (int i = 0; i < 3; i++) begin
				d_ge[t][i] = drem[t][i] >= d_sub[t];
			end
		end
	end

	// final saturation and sign
	logic [QUO_W-1:0] q_sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_sat[i] = (dquo[DIV_N][i] > QUO_W'(ofa_pkg::ONE_Q14)) ?
				QUO_W'(ofa_pkg::ONE_Q14) : dquo[DIV_N][i];
		end
	end

	// data registers for all stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				sq_s1[i]  <= {{W{1'b0}}, mag_c[i]} * {{W{1'b0}}, mag_c[i]};
				neg_s1[i] <= in_vec[i][W-1];
			end
			side_s1 <= in_side;

			sum_s2  <= RAD_W'(sq_s1[0]) + RAD_W'(sq_s1[1]) + RAD_W'(sq_s1[2]);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;

			k_s3    <= k_c;
			sum_s3  <= sum_s2;
			zero_s3 <= (sum_s2 == '0);
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;

			srad[0]  <= sum_s3 << {k_s3, 1'b0};
			srem[0]  <= '0;
			sroot[0] <= '0;
			for (int i = 0; i < 3; i++) begin
				svk[0][i] <= MK_W'(mag_s3[i]) << k_s3;
			end
			sneg[0]  <= neg_s3;
			szero[0] <= zero_s3;
			sside[0] <= side_s3;

			for (int j = 0; j < SQRT_N; j++) begin
				srem[j+1]  <= s_ge[j] ? REM_W'(s_cat[j] - s_trial[j]) : REM_W'(s_cat[j]);
				sroot[j+1] <= {sroot[j][ROOT_W-2:0], s_ge[j]};
				srad[j+1]  <= srad[j] << 2;
				svk[j+1]   <= svk[j];
				sneg[j+1]  <= sneg[j];
				szero[j+1] <= szero[j];
				sside[j+1] <= sside[j];
			end

			// numerator plus half the divisor for round-half-up
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= (NUM_W'(svk[SQRT_N][i]) << 14) +
					NUM_W'(sroot[SQRT_N] >> 1);
				dquo[0][i] <= '0;
			end
			dd[0]    <= sroot[SQRT_N][DIV_W-1:0];
			dneg[0]  <= sneg[SQRT_N];
			dzero[0] <= szero[SQRT_N];
			dside[0] <= sside[SQRT_N];

			for (int t = 0; t < DIV_N; t++) begin
				for (int i = 0; i < 3; i++) begin
					drem[t+1][i] <= d_ge[t][i] ? drem[t][i] - d_sub[t] : drem[t][i];
					dquo[t+1][i] <= {dquo[t][i][QUO_W-2:0], d_ge[t][i]};
				end
				dd[t+1]    <= dd[t];
				dneg[t+1]  <= dneg[t];
				dzero[t+1] <= dzero[t];
				dside[t+1] <= dside[t];
			end

			for (int i = 0; i < 3; i++) begin
				if (dzero[DIV_N]) begin
					out_vec[i] <= '0;
				end else if (dneg[DIV_N][i]) begin
					out_vec[i] <= ofa_pkg::OUT_W'(-q_sat[i]);
				end else begin
					out_vec[i] <= ofa_pkg::OUT_W'(q_sat[i]);
				end
			end
			out_side <= dside[DIV_N];
		end
	end

endmodule

### rtl/ofa_orth.sv
// Gram-Schmidt step: hint minus its projection on the axis, with degenerate fallback.
`timescale 1ns / 1ps
module ofa_orth #(
	parameter int SIDE_W = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic signed [ofa_pkg::OUT_W-1:0]   x_vec [3],
	input  logic signed [ofa_pkg::ALIGN_W-1:0] h_vec [3],
	input  logic [ofa_pkg::THR_W-1:0]          thresh,
	input  logic [SIDE_W-1:0]                  in_side,
	output logic                               out_valid,
	output logic signed [ofa_pkg::ZR_W-1:0]    zr_vec [3],
	output logic                               fallback,
	output logic [SIDE_W-1:0]                  out_side
);

	localparam int XW   = ofa_pkg::OUT_W;
	localparam int HW   = ofa_pkg::ALIGN_W;
	localparam int ZW   = ofa_pkg::ZR_W;
	localparam int PX_W = XW + HW;
	localparam int S_W  = PX_W + 2;
	localparam int SF_W = XW + 13;
	localparam int P_W  = S_W + XW;
	localparam int E_W  = P_W + 1;
	localparam int SQ_W = 2 * ZW;
	localparam int L_W  = SQ_W + 2;
	localparam int NSTG = 6;

	// round half away from zero, 2^-40 units to 2^-14 units
	function automatic logic signed [ZW-1:0] round_q26(input logic signed [E_W-1:0] e);
		logic [E_W-1:0] m;
		logic [E_W-1:0] q;
		m = e[E_W-1] ? E_W'(-e) : E_W'(e);
		q = (m + (E_W'(1) << 25)) >> 26;
		return e[E_W-1] ? ZW'(-q) : ZW'(q);
	endfunction

	logic [NSTG-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[NSTG-1];

	// fallback axis: y when |x1| < |x2|, else z
	logic [XW-1:0] m1_c;
	logic [XW-1:0] m2_c;
	logic          fy_c;

	always_comb begin
		m1_c = x_vec[1][XW-1] ? XW'(-x_vec[1]) : XW'(x_vec[1]);
		m2_c = x_vec[2][XW-1] ? XW'(-x_vec[2]) : XW'(x_vec[2]);
		fy_c = m1_c < m2_c;
	end

	logic signed [PX_W-1:0] xh_s1 [3];
	logic signed [SF_W-1:0] sf_s1;
	logic                   fy_s1;
	logic signed [XW-1:0]   x_s1 [3];
	logic signed [HW-1:0]   h_s1 [3];
	logic [SIDE_W-1:0]      side_s1;

	logic signed [S_W-1:0]  s_s2;
	logic signed [SF_W-1:0] sf_s2;
	logic                   fy_s2;
	logic signed [XW-1:0]   x_s2 [3];
	logic signed [HW-1:0]   h_s2 [3];
	logic [SIDE_W-1:0]      side_s2;

	logic signed [P_W-1:0]  p_s3 [3];
	logic signed [P_W-1:0]  pf_s3 [3];
	logic                   fy_s3;
	logic signed [HW-1:0]   h_s3 [3];
	logic [SIDE_W-1:0]      side_s3;

	logic signed [ZW-1:0]   zr_s4 [3];
	logic signed [ZW-1:0]   zrf_s4 [3];
	logic [SIDE_W-1:0]      side_s4;

	logic signed [ZW-1:0]   zr_s5 [3];
	logic signed [ZW-1:0]   zrf_s5 [3];
	logic [SQ_W-1:0]        sq_s5 [3];
	logic [SIDE_W-1:0]      side_s5;

	// residuals for the hint and for the fallback axis
	logic signed [E_W-1:0]  e_c [3];
	logic signed [E_W-1:0]  ef_c [3];
	logic signed [HW-1:0]   hf_c [3];
	logic [L_W-1:0]         len2_c;
	logic                   fb_c;

	always_comb begin
		hf_c[0] = '0;
		hf_c[1] = fy_s3 ? HW'(ofa_pkg::ONE_Q12) : '0;
		hf_c[2] = fy_s3 ? '0 : HW'(ofa_pkg::ONE_Q12);
		for (int i = 0; i < 3; i++) begin
			e_c[i]  = (E_W'(h_s3[i]) <<< 28) - E_W'(p_s3[i]);
			ef_c[i] = (E_W'(hf_c[i]) <<< 28) - E_W'(pf_s3[i]);
		end
		len2_c = L_W'(sq_s5[0]) + L_W'(sq_s5[1]) + L_W'(sq_s5[2]);
		fb_c   = len2_c <= L_W'(thresh);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				xh_s1[i] <= PX_W'(x_vec[i]) * PX_W'(h_vec[i]);
			end
			sf_s1   <= fy_c ? (SF_W'(x_vec[1]) <<< 12) : (SF_W'(x_vec[2]) <<< 12);
			fy_s1   <= fy_c;
			x_s1    <= x_vec;
			h_s1    <= h_vec;
			side_s1 <= in_side;

			s_s2    <= S_W'(xh_s1[0]) + S_W'(xh_s1[1]) + S_W'(xh_s1[2]);
			sf_s2   <= sf_s1;
			fy_s2   <= fy_s1;
			x_s2    <= x_s1;
			h_s2    <= h_s1;
			side_s2 <= side_s1;

			for (int i = 0; i < 3; i++) begin
				p_s3[i]  <= P_W'(s_s2) * P_W'(x_s2[i]);
				pf_s3[i] <= P_W'(sf_s2) * P_W'(x_s2[i]);
			end
			fy_s3   <= fy_s2;
			h_s3    <= h_s2;
			side_s3 <= side_s2;

			for (int i = 0; i < 3; i++) begin
				zr_s4[i]  <= round_q26(e_c[i]);
				zrf_s4[i] <= round_q26(ef_c[i]);
			end
			side_s4 <= side_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= SQ_W'(SQ_W'(zr_s4[i]) * SQ_W'(zr_s4[i]));
			end
			zr_s5   <= zr_s4;
			zrf_s5  <= zrf_s4;
			side_s5 <= side_s4;

			zr_vec   <= fb_c ? zrf_s5 : zr_s5;
			fallback <= fb_c;
			out_side <= side_s5;
		end
	end

endmodule

### rtl/orthonormal_frame_from_axis.sv
// Top level: orthonormal frame from an axis and an optional hint vector.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle: the axis vector
//   axis_x/y/z, the hint hint_x/y/z and hint_given (0 selects hint (1,0,0)).
//   Components are signed, COMPONENT_WIDTH bits, aligned internally to Q4.12.
//   Output channel (out_valid/out_ready) returns one word per input: rows
//   row0 (unit axis), row1 (unit hint-cross-axis), row2 (unit orthogonal hint),
//   all Q1.14, and used_fallback when the hint collapsed onto the axis.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the 20-bit
//   degenerate threshold; it is always ready and should be written while idle.
// Pipeline:
//   From acceptance to out_valid a word passes three 54-stage normalizers
//   (bit-per-stage square root and bit-per-stage divide), six projection
//   stages and two cross-product stages. Throughput is one word per cycle
//   while the pipeline is not held by a low out_ready.
// Reset clears all valid bits and loads the threshold with 256.
// When out_ready is low with a word waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
module orthonormal_frame_from_axis #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COMPONENT_WIDTH-1:0] axis_x,
	input  logic signed [COMPONENT_WIDTH-1:0] axis_y,
	input  logic signed [COMPONENT_WIDTH-1:0] axis_z,
	input  logic signed [COMPONENT_WIDTH-1:0] hint_x,
	input  logic signed [COMPONENT_WIDTH-1:0] hint_y,
	input  logic signed [COMPONENT_WIDTH-1:0] hint_z,
	input  logic                              hint_given,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                row0_c0,
	output logic signed [15:0]                row0_c1,
	output logic signed [15:0]                row0_c2,
	output logic signed [15:0]                row1_c0,
	output logic signed [15:0]                row1_c1,
	output logic signed [15:0]                row1_c2,
	output logic signed [15:0]                row2_c0,
	output logic signed [15:0]                row2_c1,
	output logic signed [15:0]                row2_c2,
	output logic                              used_fallback,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [19:0]                       cfg_data
);

	localparam int AW   = ofa_pkg::ALIGN_W;
	localparam int OW   = ofa_pkg::OUT_W;
	localparam int ZW   = ofa_pkg::ZR_W;
	localparam int CW   = ofa_pkg::CR_W;
	localparam int PR_W = 2 * OW;
	localparam int S1_W = 3 * AW + 1;
	localparam int S2_W = 3 * OW;
	localparam int S3_W = 3 * OW + 1;
	localparam int S4_W = 6 * OW + 1;

	// pipeline advances unless a finished word is held
	logic adv;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// threshold register
	logic [ofa_pkg::THR_W-1:0] thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ofa_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// align inputs to Q4.12
	logic signed [COMPONENT_WIDTH-1:0] raw [6];
	logic signed [AW-1:0]              al [6];

	assign raw[0] = axis_x;
	assign raw[1] = axis_y;
	assign raw[2] = axis_z;
	assign raw[3] = hint_x;
	assign raw[4] = hint_y;
	assign raw[5] = hint_z;

	for (genvar g = 0; g < 6; g++) begin : g_align
		if (COMPONENT_WIDTH > AW) begin : g_wide
			assign al[g] = AW'(raw[g] >>> (COMPONENT_WIDTH - AW));
		end else if (COMPONENT_WIDTH < AW) begin : g_narrow
			assign al[g] = {raw[g], {(AW - COMPONENT_WIDTH){1'b0}}};
		end else begin : g_same
			assign al[g] = raw[g];
		end
	end

	// hint select and zero-axis detect
	logic signed [AW-1:0] ax_c [3];
	logic signed [AW-1:0] h_c [3];
	logic                 zero_ax_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax_c[i] = al[i];
			h_c[i]  = hint_given ? al[3 + i] : '0;
		end
		if (!hint_given) begin
			h_c[0] = AW'(ofa_pkg::ONE_Q12);
		end
		zero_ax_c = (al[0] == '0) && (al[1] == '0) && (al[2] == '0);
	end

	// normalize the axis
	logic                 n1_valid;
	logic signed [OW-1:0] n1_vec [3];
	logic [S1_W-1:0]      n1_side;

	ofa_norm #(.W(AW), .SIDE_W(S1_W)) u_norm_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_vec   (ax_c),
		.in_side  ({h_c[0], h_c[1], h_c[2], zero_ax_c}),
		.out_valid(n1_valid),
		.out_vec  (n1_vec),
		.out_side (n1_side)
	);

	logic signed [OW-1:0] x_c [3];
	logic signed [AW-1:0] h1_c [3];

	always_comb begin
		h1_c[0] = n1_side[3*AW -: AW];
		h1_c[1] = n1_side[2*AW -: AW];
		h1_c[2] = n1_side[AW -: AW];
		if (n1_side[0]) begin
			x_c[0] = '0;
			x_c[1] = '0;
			x_c[2] = OW'(ofa_pkg::ONE_Q14);
		end else begin
			x_c = n1_vec;
		end
	end

	// orthogonalize the hint
	logic                 o_valid;
	logic signed [ZW-1:0] o_zr [3];
	logic                 o_fb;
	logic [S2_W-1:0]      o_side;

	ofa_orth #(.SIDE_W(S2_W)) u_orth (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (n1_valid),
		.x_vec    (x_c),
		.h_vec    (h1_c),
		.thresh   (thresh_q),
		.in_side  ({x_c[0], x_c[1], x_c[2]}),
		.out_valid(o_valid),
		.zr_vec   (o_zr),
		.fallback (o_fb),
		.out_side (o_side)
	);

	// normalize the orthogonal hint
	logic                 n2_valid;
	logic signed [OW-1:0] n2_vec [3];
	logic [S3_W-1:0]      n2_side;

	ofa_norm #(.W(ZW), .SIDE_W(S3_W)) u_norm_hint (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (o_valid),
		.in_vec   (o_zr),
		.in_side  ({o_side, o_fb}),
		.out_valid(n2_valid),
		.out_vec  (n2_vec),
		.out_side (n2_side)
	);

	logic signed [OW-1:0] x2_c [3];

	assign x2_c[0] = n2_side[3*OW -: OW];
	assign x2_c[1] = n2_side[2*OW -: OW];
	assign x2_c[2] = n2_side[OW -: OW];

	// cross product z x x: products, then differences
	logic                   cv_s1;
	logic                   cv_s2;
	logic signed [PR_W-1:0] pr_s1 [6];
	logic signed [OW-1:0]   x_s1 [3];
	logic signed [OW-1:0]   z_s1 [3];
	logic                   fb_s1;
	logic signed [CW-1:0]   c_s2 [3];
	logic signed [OW-1:0]   x_s2 [3];
	logic signed [OW-1:0]   z_s2 [3];
	logic                   fb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0;
			cv_s2 <= 1'b0;
		end else if (adv) begin
			cv_s1 <= n2_valid;
			cv_s2 <= cv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s1[0] <= PR_W'(n2_vec[1]) * PR_W'(x2_c[2]);
			pr_s1[1] <= PR_W'(n2_vec[2]) * PR_W'(x2_c[1]);
			pr_s1[2] <= PR_W'(n2_vec[2]) * PR_W'(x2_c[0]);
			pr_s1[3] <= PR_W'(n2_vec[0]) * PR_W'(x2_c[2]);
			pr_s1[4] <= PR_W'(n2_vec[0]) * PR_W'(x2_c[1]);
			pr_s1[5] <= PR_W'(n2_vec[1]) * PR_W'(x2_c[0]);
			x_s1     <= x2_c;
			z_s1     <= n2_vec;
			fb_s1    <= n2_side[0];

			c_s2[0]  <= CW'(pr_s1[0] - pr_s1[1]);
			c_s2[1]  <= CW'(pr_s1[2] - pr_s1[3]);
			c_s2[2]  <= CW'(pr_s1[4] - pr_s1[5]);
			x_s2     <= x_s1;
			z_s2     <= z_s1;
			fb_s2    <= fb_s1;
		end
	end

	// normalize the cross product; its output stage is the output register
	logic signed [OW-1:0] n3_vec [3];
	logic [S4_W-1:0]      n3_side;

	ofa_norm #(.W(CW), .SIDE_W(S4_W)) u_norm_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (cv_s2),
		.in_vec   (c_s2),
		.in_side  ({x_s2[0], x_s2[1], x_s2[2], z_s2[0], z_s2[1], z_s2[2], fb_s2}),
		.out_valid(out_valid),
		.out_vec  (n3_vec),
		.out_side (n3_side)
	);

	assign row0_c0       = n3_side[6*OW -: OW];
	assign row0_c1       = n3_side[5*OW -: OW];
	assign row0_c2       = n3_side[4*OW -: OW];
	assign row2_c0       = n3_side[3*OW -: OW];
	assign row2_c1       = n3_side[2*OW -: OW];
	assign row2_c2       = n3_side[OW -: OW];
	assign row1_c0       = n3_vec[0];
	assign row1_c1       = n3_vec[1];
	assign row1_c2       = n3_vec[2];
	assign used_fallback = n3_side[0];

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no word held at the output");

	a_row0_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row0_c0 <= 16'sd16384 && row0_c0 >= -16'sd16384 &&
			row0_c1 <= 16'sd16384 && row0_c1 >= -16'sd16384 &&
			row0_c2 <= 16'sd16384 && row0_c2 >= -16'sd16384))
		else $error("row0 component out of Q1.14 unit range");

	a_row1_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row1_c0 <= 16'sd16384 && row1_c0 >= -16'sd16384 &&
			row1_c1 <= 16'sd16384 && row1_c1 >= -16'sd16384 &&
			row1_c2 <= 16'sd16384 && row1_c2 >= -16'sd16384))
		else $error("row1 component out of Q1.14 unit range");

	a_held_word_stays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(used_fallback) && $stable(row1_c0))
		else $error("held output word changed during stall");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the orthonormal frame block: directed table, then random words.
`timescale 1ns / 1ps
module tb_top;

	localparam int  LATENCY   = 170;
	localparam int  LIMIT     = 200000;
	localparam int  N_RANDOM  = 1000;
	localparam int  HOLD_LEN  = 600;

	typedef longint vec3_t [3];

	typedef struct {
		logic signed [15:0] ax, ay, az, hx, hy, hz;
		logic               given;
	} axis_word_t;

	typedef struct {
		logic signed [15:0] c [9];
		logic               fb;
	} frame_t;

	typedef struct {
		axis_word_t w;
		bit         known;
		frame_t     f;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic signed [15:0] hint_x = '0, hint_y = '0, hint_z = '0;
	logic hint_given = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic signed [15:0] row0_c0, row0_c1, row0_c2, row1_c0, row1_c1, row1_c2;
	logic signed [15:0] row2_c0, row2_c1, row2_c2;
	logic used_fallback;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [ofa_pkg::THR_W-1:0] cfg_data = '0;

	// predictor copy of the threshold register
	logic [ofa_pkg::THR_W-1:0] thresh_model = ofa_pkg::THRESH_RESET;
	frame_t frames_due [$];
	int unsigned n_err = 0, n_sent = 0, n_got = 0, n_fb = 0, cycles = 0;
	bit quiet = 1'b0;
	bit held = 1'b0;

	always #1 clk = ~clk;

	orthonormal_frame_from_axis #(.COMPONENT_WIDTH(16)) dut (.*);

	// ---------------- frame predictor ----------------
	function automatic longint unsigned mag(longint v);
		return v < 0 ? 64'd0 - longint'(v) : longint'(v);
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void unit_vec(input vec3_t v, output vec3_t o);
		longint unsigned s, r, num, q;
		int unsigned k;
		s = 0;
		k = 0;
		for (int i = 0; i < 3; i++) s += mag(v[i]) * mag(v[i]);
		if (s == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (s < (64'd1 << 60)) begin
			s <<= 2;
			k++;
		end
		r = root64(s);
		for (int i = 0; i < 3; i++) begin
			num = mag(v[i]) << (14 + k);
			q = (num + r / 2) / r;
			if (q > ofa_pkg::ONE_Q14) q = ofa_pkg::ONE_Q14;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	// hint residual against the unit axis, rounded to Q.14
	function automatic void residual(input vec3_t x, input vec3_t h, output vec3_t z);
		longint s, e;
		longint unsigned q;
		s = x[0] * h[0] + x[1] * h[1] + x[2] * h[2];
		for (int i = 0; i < 3; i++) begin
			e = h[i] * (longint'(1) << 28) - s * x[i];
			q = (mag(e) + (64'd1 << 25)) >> 26;
			z[i] = e < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic frame_t predict_frame(axis_word_t w, logic [ofa_pkg::THR_W-1:0] thr);
		vec3_t a, h, x, zr, z, c, y;
		longint unsigned len2;
		frame_t f;
		a = '{w.ax, w.ay, w.az};
		if (w.given) h = '{w.hx, w.hy, w.hz};
		else h = '{ofa_pkg::ONE_Q12, 0, 0};
		if (a[0] == 0 && a[1] == 0 && a[2] == 0) x = '{0, 0, ofa_pkg::ONE_Q14};
		else unit_vec(a, x);
		residual(x, h, zr);
		len2 = 0;
		for (int i = 0; i < 3; i++) len2 += mag(zr[i]) * mag(zr[i]);
		f.fb = (len2 <= longint'(thr));
		if (f.fb) begin
			if (mag(x[1]) < mag(x[2])) h = '{0, ofa_pkg::ONE_Q12, 0};
			else h = '{0, 0, ofa_pkg::ONE_Q12};
			residual(x, h, zr);
		end
		unit_vec(zr, z);
		c[0] = z[1] * x[2] - z[2] * x[1];
		c[1] = z[2] * x[0] - z[0] * x[2];
		c[2] = z[0] * x[1] - z[1] * x[0];
		unit_vec(c, y);
		for (int i = 0; i < 3; i++) begin
			f.c[i]     = x[i][15:0];
			f.c[3 + i] = y[i][15:0];
			f.c[6 + i] = z[i][15:0];
		end
		return f;
	endfunction

	// ---------------- drivers ----------------
	function automatic int gap_len();
		if (quiet || $urandom_range(0, 99) >= 4) return 0;
		return $urandom_range(1, 4);
	endfunction

	task automatic send_word(axis_word_t w, bit known, frame_t f);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		{axis_x, axis_y, axis_z} <= {w.ax, w.ay, w.az};
		{hint_x, hint_y, hint_z} <= {w.hx, w.hy, w.hz};
		hint_given <= w.given;
		do @(posedge clk); while (!in_ready);
		frames_due.push_back(known ? f : predict_frame(w, thresh_model));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic write_thresh(logic [ofa_pkg::THR_W-1:0] v);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		thresh_model = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every frame is back, then let the pipeline drain
	task automatic drain();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3: return 16'(signed'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// random word: half of them near-parallel hints to probe the degenerate test
	function automatic axis_word_t rand_word();
		axis_word_t w;
		int sh;
		w.ax = rnd16(); w.ay = rnd16(); w.az = rnd16();
		w.given = $urandom_range(0, 3) != 0;
		sh = $urandom_range(0, 6);
		case ($urandom_range(0, 3))
			0, 1: begin
				w.hx = (w.ax >>> sh) + 16'(signed'($urandom_range(0, 6)) - 3);
				w.hy = (w.ay >>> sh) + 16'(signed'($urandom_range(0, 6)) - 3);
				w.hz = (w.az >>> sh) + 16'(signed'($urandom_range(0, 6)) - 3);
			end
			default: begin
				w.hx = rnd16(); w.hy = rnd16(); w.hz = rnd16();
			end
		endcase
		if ($urandom_range(0, 19) == 0) {w.ax, w.ay, w.az} = '0;
		return w;
	endfunction

	function automatic dir_row_t mk(int ax, int ay, int az, int hx, int hy, int hz,
			bit g, bit known = 0, int c0 = 0, int c1 = 0, int c2 = 0, int c3 = 0,
			int c4 = 0, int c5 = 0, int c6 = 0, int c7 = 0, int c8 = 0, bit fb = 0);
		dir_row_t r;
		r.w = '{16'(ax), 16'(ay), 16'(az), 16'(hx), 16'(hy), 16'(hz), g};
		r.known = known;
		r.f.c = '{16'(c0), 16'(c1), 16'(c2), 16'(c3), 16'(c4), 16'(c5),
			16'(c6), 16'(c7), 16'(c8)};
		r.f.fb = fb;
		return r;
	endfunction

	// ---------------- receiver ----------------
	initial begin
		forever begin
			@(negedge clk);
			if (!held && n_sent >= 400) begin
				// long back-pressure so the pipeline fills and in_ready drops
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_LEN - 1) @(negedge clk);
			end else
				out_ready <= quiet || ($urandom_range(0, 99) >= 10);
		end
	end

	// ---------------- checker ----------------
	always @(posedge clk) begin
		frame_t got, want;
		bit bad;
		if (arst_n && out_valid && out_ready) begin
			got.c = '{row0_c0, row0_c1, row0_c2, row1_c0, row1_c1, row1_c2,
				row2_c0, row2_c1, row2_c2};
			got.fb = used_fallback;
			n_got++;
			if (frames_due.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected word at cycle %0d", cycles);
			end else begin
				want = frames_due.pop_front();
				n_fb += want.fb;
				bad = (got.fb !== want.fb);
				for (int i = 0; i < 9; i++) bad |= (got.c[i] !== want.c[i]);
				if (bad) begin
					n_err++;
					if (n_err <= 10)
						$display("word %0d mismatch: exp %p got %p", n_got, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		dir_row_t rows [$];
		logic [ofa_pkg::THR_W-1:0] phase_thr [4];
		frame_t none;
		none.fb = 0;
		none.c = '{default: 0};

		// zero axis, default hint
		rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1,
			0, 0, 16384, 0, -16384, 0, 16384, 0, 0, 0));
		// axis along x with default hint: degenerate, restarts on axis 2
		rows.push_back(mk(4096, 0, 0, 0, 0, 0, 0, 1,
			16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1));
		// hint fields ignored when not given
		rows.push_back(mk(0, 0, 0, 123, -77, 9, 0, 1,
			0, 0, 16384, 0, -16384, 0, 16384, 0, 0, 0));
		rows.push_back(mk(0, 0, 0, 0, 0, 0, 1));
		rows.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767, 1));
		rows.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768, 1));
		rows.push_back(mk(32767, -32768, 0, 0, 0, 32767, 1));
		rows.push_back(mk(0, 4096, 0, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, -4096, 0, 0, 0, 0));
		rows.push_back(mk(0, 1, 1, 0, 0, 0, 0));
		rows.push_back(mk(1, 0, 0, 1, 0, 0, 1));
		rows.push_back(mk(1000, 2000, 3000, 2000, 4000, 6000, 1));
		rows.push_back(mk(1000, 2000, 3000, -500, -1000, -1500, 1));
		rows.push_back(mk(1000, 2000, 3000, 2000, 4000, 6001, 1));
		rows.push_back(mk(0, 3, 5, 0, 0, 0, 1));
		rows.push_back(mk(0, 5, 3, 0, 0, 0, 1));
		rows.push_back(mk(-1, -1, -1, 32767, -32768, 1, 1));
		rows.push_back(mk(-32768, 0, 0, 32767, 0, 0, 1));
		rows.push_back(mk(5, -7, 11, -32768, 0, 32767, 1));
		rows.push_back(mk(-21846, 21845, -1, 1, 0, 0, 0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_word(rows[i].w, rows[i].known, rows[i].f);
		drain();

		phase_thr = '{20'd0, 20'hfffff, 20'($urandom), ofa_pkg::THRESH_RESET};
		for (int p = 0; p < 4; p++) begin
			write_thresh(phase_thr[p]);
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				quiet = (p == 1 && i >= 50 && i < 200);
				send_word(rand_word(), 0, none);
			end
			quiet = 1'b0;
			drain();
		end

		$display("sent %0d words over five threshold settings, %0d frames checked",
			n_sent, n_got);
		$display("%0d frames took the axis fallback", n_fb);
		if (n_err == 0 && frames_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/ofa_pkg.sv
rtl/ofa_norm.sv
rtl/ofa_orth.sv
rtl/orthonormal_frame_from_axis.sv
tb/tb_top.sv
